FILE: src/psdd_pkg.sv
package psdd_pkg;
   localparam int SENDERS_DEF = 16;
   localparam int RING_SIZE_DEF = 16;
   localparam logic [1:0] ST_KNOWN = 2'd0;
   localparam logic [1:0] ST_NEW = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_SWEEP = 2'd3;
   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_SWEEP = 1'b1;
   localparam logic [31:0] EXPIRY_RESET = 32'd60;

   typedef struct packed {
      logic       start;
      logic       scan_step;
      logic       create;
      logic       seq_check;
      logic       gap_step;
      logic       sweep_step;
      logic       finish;
   } psdd_cmd_type;

   typedef struct packed {
      logic       is_sweep;
      logic       scan_last;
      logic       found;
      logic       has_free;
      logic       gap_more;
   } psdd_sts_type;
endpackage

FILE: src/psdd_if.sv
interface psdd_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [63:0] sender_id_high;
   logic [63:0] sender_id_mid;
   logic [31:0] sender_id_low;
   logic [31:0] seq_number;
   logic [31:0] now;
   modport source (output valid, op, sender_id_high, sender_id_mid, sender_id_low,
                   seq_number, now, input ready);
   modport sink (input valid, op, sender_id_high, sender_id_mid, sender_id_low,
                 seq_number, now, output ready);
endinterface

interface psdd_rsp_if;
   logic       valid;
   logic       ready;
   logic       fresh;
   logic [1:0] status;
   logic [4:0] evicted_count;
   modport source (output valid, fresh, status, evicted_count, input ready);
   modport sink (input valid, fresh, status, evicted_count, output ready);
endinterface

interface psdd_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: src/psdd_datapath.sv
module psdd_datapath
   import psdd_pkg::*;
#(
   parameter int SENDERS = SENDERS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  psdd_cmd_type cmd,
   output psdd_sts_type sts,
   input  logic         in_op,
   input  logic [63:0]  in_hi,
   input  logic [63:0]  in_mid,
   input  logic [31:0]  in_lo,
   input  logic [31:0]  in_seq,
   input  logic [31:0]  in_now,
   input  logic [31:0]  expiry,
   output logic         res_fresh,
   output logic [1:0]   res_status,
   output logic [4:0]   res_evicted
);
   // ring slot is the low bits of the number, so the ring size is a fixed power of two
   localparam int RING_SIZE = RING_SIZE_DEF;
   localparam int SW = (SENDERS > 1) ? $clog2(SENDERS) : 1;
   localparam int RW = $clog2(RING_SIZE);
   localparam int RD = SENDERS * RING_SIZE;
   localparam int AW = (RD > 1) ? $clog2(RD) : 1;

   logic [SENDERS-1:0] valid_ff, valid_in;
   logic [63:0] key_hi_ff [SENDERS];
   logic [63:0] key_mid_ff [SENDERS];
   logic [31:0] key_lo_ff [SENDERS];
   logic [31:0] high_ff [SENDERS];
   logic [31:0] seen_ff [SENDERS];
   logic [RING_SIZE-1:0] rv_ff [SENDERS];
   logic [31:0] ring_mem [RD];

   logic        op_ff;
   logic [63:0] hi_ff, mid_ff;
   logic [31:0] lo_ff, seq_ff, now_ff, n_ff;
   logic [SW:0] idx_ff;
   logic [SW-1:0] ent_ff, free_ff;
   logic        found_ff, free_ok_ff;
   logic        fresh_ff;
   logic [1:0]  status_ff;
   logic [4:0]  evict_ff;
   logic [31:0] rd_ff;
   logic        rd_phase_ff;

   logic [SW-1:0] idx;
   logic hit, age_over;
   logic [31:0] high_e;
   logic [RW-1:0] slot_seq, slot_n;

   assign idx = idx_ff[SW-1:0];
   assign hit = valid_ff[idx] && key_hi_ff[idx] == hi_ff && key_mid_ff[idx] == mid_ff
                && key_lo_ff[idx] == lo_ff;
   assign age_over = valid_ff[idx] && ((now_ff - seen_ff[idx]) > expiry);
   assign high_e = high_ff[ent_ff];
   assign slot_seq = seq_ff[RW-1:0];
   assign slot_n = n_ff[RW-1:0];

   assign sts.is_sweep = op_ff;
   assign sts.scan_last = (idx_ff == (SW+1)'(SENDERS - 1));
   assign sts.found = found_ff;
   assign sts.has_free = free_ok_ff;
   assign sts.gap_more = (n_ff != seq_ff);

   assign res_fresh = fresh_ff;
   assign res_status = status_ff;
   assign res_evicted = evict_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.create) valid_in[free_ff] = 1'b1;
      if (cmd.sweep_step && age_over) valid_in[idx] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ring read, registered; seq_check first reads the ring (S_READ), then decides (S_CHECK)
   always_ff @(posedge clock) begin
      rd_ff <= ring_mem[AW'({ent_ff, slot_seq})];
      if (cmd.gap_step) ring_mem[AW'({ent_ff, slot_n})] <= n_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_phase_ff <= 1'b0;
      end else if (cmd.start) begin
         rd_phase_ff <= 1'b0;
      end else if (cmd.seq_check) begin
         rd_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff <= in_op;
         hi_ff <= in_hi;
         mid_ff <= in_mid;
         lo_ff <= in_lo;
         seq_ff <= in_seq;
         now_ff <= in_now;
         idx_ff <= '0;
         found_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         fresh_ff <= 1'b0;
         evict_ff <= '0;
         status_ff <= (in_op == OP_SWEEP) ? ST_SWEEP : ST_KNOWN;
      end
      if (cmd.scan_step || cmd.sweep_step) idx_ff <= idx_ff + (SW+1)'(1);
      if (cmd.scan_step) begin
         if (hit && !found_ff) begin
            found_ff <= 1'b1;
            ent_ff <= idx;
         end
         if (!valid_ff[idx] && !free_ok_ff) begin
            free_ok_ff <= 1'b1;
            free_ff <= idx;
         end
      end
      if (cmd.sweep_step && age_over && evict_ff != 5'd31) evict_ff <= evict_ff + 5'd1;
      if (cmd.create) begin
         key_hi_ff[free_ff] <= hi_ff;
         key_mid_ff[free_ff] <= mid_ff;
         key_lo_ff[free_ff] <= lo_ff;
         high_ff[free_ff] <= seq_ff;
         seen_ff[free_ff] <= now_ff;
         rv_ff[free_ff] <= '0;
         fresh_ff <= 1'b1;
         status_ff <= ST_NEW;
      end
      if (cmd.finish && !op_ff && !found_ff && !free_ok_ff) status_ff <= ST_FULL;
      if (cmd.seq_check && rd_phase_ff) begin
         seen_ff[ent_ff] <= now_ff;
         if (seq_ff > high_e) begin
            fresh_ff <= 1'b1;
            high_ff[ent_ff] <= seq_ff;
            n_ff <= ((seq_ff - high_e - 32'd1) > 32'(RING_SIZE))
                    ? seq_ff - 32'(RING_SIZE) : high_e + 32'd1;
         end else begin
            n_ff <= seq_ff;
            if (seq_ff != high_e && rv_ff[ent_ff][slot_seq] && rd_ff == seq_ff) begin
               fresh_ff <= 1'b1;
               rv_ff[ent_ff][slot_seq] <= 1'b0;
            end
         end
      end
      if (cmd.gap_step) begin
         rv_ff[ent_ff][slot_n] <= 1'b1;
         n_ff <= n_ff + 32'd1;
      end
   end
endmodule

FILE: src/psdd_ctrl.sv
module psdd_ctrl
   import psdd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output psdd_cmd_type cmd,
   input  psdd_sts_type sts
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_SWEEP = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_GAP = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;
   localparam logic [2:0] S_OUT = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.start = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.is_sweep) begin
               state_in = S_SWEEP;
            end else begin
               cmd.scan_step = 1'b1;
               if (sts.scan_last) state_in = S_DONE;
            end
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.scan_last) state_in = S_OUT;
         end
         S_DONE: begin
            if (sts.found) begin
               state_in = S_READ;
            end else begin
               cmd.finish = 1'b1;
               if (sts.has_free) cmd.create = 1'b1;
               state_in = S_OUT;
            end
         end
         S_READ: begin
            cmd.seq_check = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.seq_check = 1'b1;
            state_in = S_GAP;
         end
         S_GAP: begin
            if (sts.gap_more) cmd.gap_step = 1'b1;
            else state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

FILE: src/per_sender_duplicate_discard.sv
// Per-sender duplicate discard.
// req: one item per transfer (op, 160-bit sender id, seq_number, now).
// rsp: one result per item (fresh, status, evicted_count), held until taken.
// csr: write-only expiry_ticks; write only while no item is in flight.
// Path from the req transfer to rsp_valid: for a sweep, a new sender or a full
// table, the table walk (the table is walked one entry a cycle); for a known
// sender, the walk, the ring read and the check, plus a gap-fill step for each
// missing number recorded (up to RING_SIZE_DEF).
// One item is in the block at a time; req_ready is high only between items.
// The sequential table walk and gap fill set the rate.
// Reset clears the sender valid bits and restores expiry_ticks to 60; the
// result register stays valid while rsp_ready is low and no new item is taken.
module per_sender_duplicate_discard
   import psdd_pkg::*;
#(
   parameter int SENDERS = SENDERS_DEF
) (
   input logic clock,
   input logic reset,
   psdd_req_if.sink req,
   psdd_rsp_if.source rsp,
   psdd_csr_if.sink csr
);
   psdd_cmd_type cmd;
   psdd_sts_type sts;
   logic [31:0] expiry_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff <= EXPIRY_RESET;
      end else if (csr.valid) begin
         expiry_ff <= csr.data;
      end
   end

   psdd_ctrl u_ctrl (
      .clock, .reset,
      .req_fire (req.valid && req.ready),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd, .sts
   );

   psdd_datapath #(.SENDERS(SENDERS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_op (req.op),
      .in_hi (req.sender_id_high),
      .in_mid (req.sender_id_mid),
      .in_lo (req.sender_id_low),
      .in_seq (req.seq_number),
      .in_now (req.now),
      .expiry (expiry_ff),
      .res_fresh (rsp.fresh),
      .res_status (rsp.status),
      .res_evicted (rsp.evicted_count)
   );
endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import psdd_pkg::*;

   localparam int NSEND = 16;
   localparam int NRING = 16;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic        op;
      logic [63:0] id_high;
      logic [63:0] id_mid;
      logic [31:0] id_low;
      logic [31:0] seq;
      logic [31:0] now;
   } pkt_type;

   typedef struct packed {
      logic       fresh;
      logic [1:0] status;
      logic [4:0] evicted;
   } verdict_type;

   typedef struct {
      pkt_type     pkt;
      logic        has_verdict;
      verdict_type verdict;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psdd_req_if req ();
   psdd_rsp_if rsp ();
   psdd_csr_if csr ();

   per_sender_duplicate_discard dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // predictor state
   logic [31:0] expiry;
   logic        tab_valid [NSEND];
   logic [63:0] tab_high [NSEND];
   logic [63:0] tab_mid [NSEND];
   logic [31:0] tab_low [NSEND];
   logic [31:0] tab_top [NSEND];
   logic [31:0] tab_seen [NSEND];
   logic [31:0] gap_num [NSEND][NRING];
   logic        gap_valid [NSEND][NRING];

   verdict_type verdicts_due [$];
   int       errors = 0;
   int       quiet = 0;
   bit       rsp_hold = 0;
   bit       stall_free = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic verdict_type predict_verdict(pkt_type p);
      verdict_type v;
      int       e;
      longint unsigned first;
      v = '0;
      e = -1;
      if (p.op == OP_SWEEP) begin
         for (int i = 0; i < NSEND; i++) begin
            if (tab_valid[i] && (p.now - tab_seen[i]) > expiry) begin
               tab_valid[i] = 1'b0;
               if (v.evicted < 31) v.evicted++;
            end
         end
         v.status = ST_SWEEP;
         return v;
      end
      for (int i = 0; i < NSEND; i++) begin
         if (e < 0 && tab_valid[i] && tab_high[i] == p.id_high && tab_mid[i] == p.id_mid &&
             tab_low[i] == p.id_low) e = i;
      end
      if (e >= 0) begin
         tab_seen[e] = p.now;
         v.status = ST_KNOWN;
         if (p.seq > tab_top[e]) begin
            first = longint'(tab_top[e]) + 1;
            if (longint'(p.seq) - first > NRING) first = longint'(p.seq) - NRING;
            for (longint unsigned n = first; n < longint'(p.seq); n++) begin
               gap_num[e][n % NRING] = n[31:0];
               gap_valid[e][n % NRING] = 1'b1;
            end
            tab_top[e] = p.seq;
            v.fresh = 1'b1;
         end else if (p.seq < tab_top[e]) begin
            if (gap_valid[e][p.seq % NRING] && gap_num[e][p.seq % NRING] == p.seq) begin
               gap_valid[e][p.seq % NRING] = 1'b0;
               v.fresh = 1'b1;
            end
         end
         return v;
      end
      for (int i = 0; i < NSEND; i++) if (e < 0 && !tab_valid[i]) e = i;
      if (e < 0) begin
         v.status = ST_FULL;
         return v;
      end
      tab_valid[e] = 1'b1;
      tab_high[e] = p.id_high;
      tab_mid[e] = p.id_mid;
      tab_low[e] = p.id_low;
      tab_top[e] = p.seq;
      tab_seen[e] = p.now;
      for (int s = 0; s < NRING; s++) gap_valid[e][s] = 1'b0;
      v.fresh = 1'b1;
      v.status = ST_NEW;
      return v;
   endfunction

   // ids drawn from a small pool so senders recur; a few fully random
   function automatic pkt_type random_packet(int pool, int t);
      pkt_type p;
      int   k;
      p.op = OP_PACKET;
      k = $urandom_range(pool - 1);
      if ($urandom_range(9) == 0) begin
         p.id_high = {$urandom, $urandom};
         p.id_mid = {$urandom, $urandom};
         p.id_low = $urandom;
      end else begin
         p.id_high = {32'hA5A5_0000 ^ k, 32'(k * 7)};
         p.id_mid = {~32'(k), 32'(k)};
         p.id_low = 32'(k) | ((k & 1) ? 32'h8000_0000 : 32'h0);
      end
      case ($urandom_range(3))
         0: p.seq = $urandom;
         1: p.seq = 32'hFFFF_FFF0 + $urandom_range(15);
         default: p.seq = 1000 + $urandom_range(60);
      endcase
      p.now = 32'(t);
      return p;
   endfunction

   // valid drops only when the sender idles; otherwise the next item follows
   task automatic idle_req();
      if (!stall_free && $urandom_range(3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(16, 1)) @(negedge clock);
      end
   endtask

   task automatic send_item(pkt_type p);
      idle_req();
      req.valid <= 1'b1;
      req.op <= p.op;
      req.sender_id_high <= p.id_high;
      req.sender_id_mid <= p.id_mid;
      req.sender_id_low <= p.id_low;
      req.seq_number <= p.seq;
      req.now <= p.now;
      do @(posedge clock); while (!req.ready);
      verdicts_due.push_back(predict_verdict(p));
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_expiry(logic [31:0] val);
      drain();
      csr.valid <= 1'b1;
      csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      expiry = val;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   // result sink
   initial begin
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (rsp_hold || (!stall_free && $urandom_range(4) == 0)) begin
            rsp.ready <= 1'b0;
            if (!rsp_hold) repeat ($urandom_range(16, 1)) @(negedge clock);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (verdicts_due.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            verdict_type w;
            w = verdicts_due.pop_front();
            if (rsp.fresh !== w.fresh) begin
               $error("fresh: expected %0d, got %0d", w.fresh, rsp.fresh);
               errors++;
            end
            if (rsp.status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp.status);
               errors++;
            end
            if (rsp.evicted_count !== w.evicted) begin
               $error("evicted_count: expected %0d, got %0d", w.evicted, rsp.evicted_count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > WATCHDOG) begin
         $display("per_sender_duplicate_discard verification failed");
         $finish;
      end
   end

   // hold off the receiver for a long stretch
   task automatic long_hold();
      rsp_hold = 1;
      repeat (400) @(negedge clock);
      rsp_hold = 0;
   endtask

   initial begin
      row_type rows [$];
      pkt_type p;
      int   t;
      verdict_type v;
      req.valid = 1'b0;
      req.op = OP_PACKET;
      req.sender_id_high = '0;
      req.sender_id_mid = '0;
      req.sender_id_low = '0;
      req.seq_number = '0;
      req.now = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      expiry = EXPIRY_RESET;
      for (int i = 0; i < NSEND; i++) begin
         tab_valid[i] = 1'b0;
         for (int s = 0; s < NRING; s++) begin
            gap_valid[i][s] = 1'b0;
            gap_num[i][s] = '0;
         end
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: all-zero id, all-ones id, gaps, repeats, sweeps
      rows.push_back('{'{OP_SWEEP, '0, '0, '0, '0, 32'd0}, 1, '{1'b0, ST_SWEEP, 5'd0}});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'd0, 32'd0}, 1, '{1'b1, ST_NEW, 5'd0}});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'd0, 32'd1}, 1, '{1'b0, ST_KNOWN, 5'd0}});
      rows.push_back('{'{OP_PACKET, '1, '1, '1, '1, '1}, 1, '{1'b1, ST_NEW, 5'd0}});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'd5, 32'd2}, 0, '0});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'd3, 32'd3}, 0, '0});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'd3, 32'd3}, 0, '0});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'd100, 32'd4}, 0, '0});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'd83, 32'd4}, 0, '0});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'd84, 32'd4}, 0, '0});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'd99, 32'd4}, 0, '0});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'd4, 32'd4}, 0, '0});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, '1, 32'd5}, 0, '0});
      rows.push_back('{'{OP_PACKET, '0, '0, '0, 32'hFFFF_FFF0, 32'd5}, 0, '0});
      rows.push_back('{'{OP_SWEEP, '1, '1, '1, '1, 32'd70}, 0, '0});
      for (int k = 0; k < 17; k++)
         rows.push_back('{'{OP_PACKET, 64'(k), 64'd1, 32'd2, 32'(k), 32'd80}, 0, '0});
      rows.push_back('{'{OP_SWEEP, '0, '0, '0, '0, 32'd500}, 1, '{1'b0, ST_SWEEP, 5'd16}});
      foreach (rows[i]) begin
         v = predict_verdict(rows[i].pkt);
         // predict once, check any expected verdict, then drive the row directly
         if (rows[i].has_verdict) begin
            if (v.fresh !== rows[i].verdict.fresh) begin
               $error("fresh: expected %0d, got %0d", rows[i].verdict.fresh, v.fresh);
               errors++;
            end
            if (v.status !== rows[i].verdict.status) begin
               $error("status: expected %0d, got %0d", rows[i].verdict.status, v.status);
               errors++;
            end
            if (v.evicted !== rows[i].verdict.evicted) begin
               $error("evicted_count: expected %0d, got %0d", rows[i].verdict.evicted,
                      v.evicted);
               errors++;
            end
         end
         verdicts_due.push_back(v);
         req.valid <= 1'b1;
         req.op <= rows[i].pkt.op;
         req.sender_id_high <= rows[i].pkt.id_high;
         req.sender_id_mid <= rows[i].pkt.id_mid;
         req.sender_id_low <= rows[i].pkt.id_low;
         req.seq_number <= rows[i].pkt.seq;
         req.now <= rows[i].pkt.now;
         do @(posedge clock); while (!req.ready);
         @(negedge clock);
         idle_req();
      end

      write_expiry(32'd0);
      t = 1000;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: write_expiry('1);
            2: write_expiry(32'd40);
            3: write_expiry(32'd200);
            4: write_expiry(EXPIRY_RESET);
            default: ;
         endcase
         if (phase == 1) fork long_hold(); join_none
         if (phase == 4) stall_free = 1;
         for (int n = 0; n < 400; n++) begin
            t += $urandom_range(3);
            if ($urandom_range(14) == 0) begin
               p = '{OP_SWEEP, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom,
                     32'(t)};
               if ($urandom_range(7) == 0) p.now = $urandom;
            end else begin
               p = random_packet(phase == 2 ? 24 : 12, t);
            end
            send_item(p);
            if (phase == 3 && n == 200) drain();
         end
      end

      drain();
      if (errors == 0)
         $display("per_sender_duplicate_discard verification clean");
      else
         $display("per_sender_duplicate_discard verification failed");
      $finish;
   end
endmodule

FILE: per_sender_duplicate_discard.f
src/psdd_pkg.sv
src/psdd_if.sv
src/psdd_datapath.sv
src/psdd_ctrl.sv
src/per_sender_duplicate_discard.sv
sim/testbench.sv
